>>> rtl/zigzag_rail_reorder_top_assert.svh
// Assertion macros for the zigzag rail reorder checker.
// Expects signals named clock and reset in the scope of use.
`ifndef ZIGZAG_RAIL_REORDER_TOP_ASSERT_SVH
`define ZIGZAG_RAIL_REORDER_TOP_ASSERT_SVH
// check cons in the same cycle as ante
`define ZRR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// check cons in the cycle after ante
`define ZRR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/zrr_pkg.sv
// Shared types and constants for the zigzag rail reorder block.
// No dependencies.
`default_nettype none
package zrr_pkg;
   localparam int BYTE_W      = 8;
   localparam int RC_W        = 5;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              keep;
      logic              last;
      logic              dropped;
   } entry_type;

   typedef enum logic {
      BK_STORE,
      BK_DRAIN
   } back_state_type;
endpackage
`default_nettype wire

>>> rtl/zrr_front.sv
// Front end: assigns a zigzag rail to each incoming byte and flags overflow.
// Depends on zrr_pkg.
`default_nettype none
module zrr_front import zrr_pkg::*; #(
   parameter  int MAX_LEN   = 64,
   parameter  int MAX_RAILS = 16,
   localparam int RAIL_W    = $clog2(MAX_RAILS),
   localparam int FILL_W    = $clog2(MAX_LEN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [RC_W-1:0]   rail_count,
   input  logic              take,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_last,
   output entry_type         entry,
   output logic [RAIL_W-1:0] entry_rail
);
   localparam logic [RC_W-1:0] RC_MAX = RC_W'(MAX_RAILS);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [RAIL_W-1:0] rail_ff, rail_in;
   logic              up_ff, up_in;
   logic              ovf_ff, ovf_in;

   logic [RC_W-1:0]   top_wide;
   logic [RAIL_W-1:0] top_rail;
   logic [RAIL_W-1:0] rail_sel;
   logic [RAIL_W-1:0] rail_adv;
   logic              flip;
   logic              up_new;
   logic              keep;

   always_comb begin
      if (rail_count == '0) begin
         top_wide = '0;
      end else if (rail_count > RC_MAX) begin
         top_wide = RC_MAX - RC_W'(1);
      end else begin
         top_wide = rail_count - RC_W'(1);
      end
      top_rail = top_wide[RAIL_W-1:0];
      rail_sel = (rail_ff > top_rail) ? top_rail : rail_ff;
      flip     = (top_rail != '0) && ((rail_sel == '0) || (rail_sel == top_rail));
      up_new   = up_ff ^ flip;
      if (top_rail == '0) begin
         rail_adv = '0;
      end else if (up_new) begin
         rail_adv = rail_sel - RAIL_W'(1);
      end else begin
         rail_adv = rail_sel + RAIL_W'(1);
      end
      keep = fill_ff < FILL_W'(MAX_LEN);
   end

   always_comb begin
      fill_in = fill_ff;
      rail_in = rail_ff;
      up_in   = up_ff;
      ovf_in  = ovf_ff;
      if (take) begin
         if (in_last) begin
            fill_in = '0;
            rail_in = '0;
            up_in   = 1'b1;
            ovf_in  = 1'b0;
         end else if (keep) begin
            fill_in = fill_ff + FILL_W'(1);
            rail_in = rail_adv;
            up_in   = up_new;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rail_ff <= '0;
         up_ff   <= 1'b1;
         ovf_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         rail_ff <= rail_in;
         up_ff   <= up_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_comb begin
      entry.data    = in_byte;
      entry.keep    = keep;
      entry.last    = in_last;
      entry.dropped = ovf_ff | ~keep;
      entry_rail    = rail_sel;
   end
endmodule
`default_nettype wire

>>> rtl/zrr_queue.sv
// Small register FIFO between the front end and the reorder engine.
// Depends on zrr_pkg.
`default_nettype none
module zrr_queue import zrr_pkg::*; #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         not_empty
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [W-1:0]     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      full      = cnt_ff == (PTR_W+1)'(QUEUE_DEPTH);
      not_empty = cnt_ff != '0;
      pop_data  = slot_ff[rd_ff];
      wr_in     = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in     = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in    = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

>>> rtl/zrr_back.sv
// Reorder engine: keeps one linked list per rail and drains them in rail order.
// Depends on zrr_pkg.
`default_nettype none
module zrr_back import zrr_pkg::*; #(
   parameter  int MAX_LEN   = 64,
   parameter  int MAX_RAILS = 16,
   localparam int RAIL_W    = $clog2(MAX_RAILS),
   localparam int IDX_W     = $clog2(MAX_LEN)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  entry_type         q_entry,
   input  logic [RAIL_W-1:0] q_rail,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [BYTE_W-1:0] out_byte,
   output logic              out_last,
   output logic              out_dropped
);
   back_state_type state_ff, state_in;

   logic [BYTE_W-1:0] byte_mem [MAX_LEN];
   logic [IDX_W-1:0]  next_mem [MAX_LEN];

   logic [IDX_W-1:0]     head_ff [MAX_RAILS];
   logic [IDX_W-1:0]     tail_ff [MAX_RAILS];
   logic [MAX_RAILS-1:0] nonempty_ff;
   logic [IDX_W-1:0]     fill_ff;
   logic                 first_ff;
   logic                 drop_ff;
   logic [RAIL_W-1:0]    drn_rail_ff;
   logic [IDX_W-1:0]     drn_idx_ff;
   logic                 s1_v_ff;
   logic [BYTE_W-1:0]    byte_q_ff;
   logic [IDX_W-1:0]     next_q_ff;
   logic                 s2_v_ff;
   logic [BYTE_W-1:0]    s2_byte_ff;
   logic                 s2_last_ff;
   logic                 s2_drop_ff;

   logic                 store_fire;
   logic                 draining;
   logic [RAIL_W-1:0]    tail_addr;
   logic [IDX_W-1:0]     tail_rd;
   logic [IDX_W-1:0]     head_rd;
   logic [MAX_RAILS-1:0] cand;
   logic                 nxt_found;
   logic [RAIL_W-1:0]    nxt_rail;
   logic                 at_tail;
   logic                 end_now;
   logic                 s1_move;
   logic                 s1_free;
   logic                 issue;
   logic                 jump;
   logic [RAIL_W-1:0]    issue_rail;
   logic [IDX_W-1:0]     issue_idx;
   logic                 finish;

   always_comb begin
      store_fire = (state_ff == BK_STORE) && q_valid;
      draining   = state_ff == BK_DRAIN;
      tail_addr  = draining ? drn_rail_ff : q_rail;
      tail_rd    = tail_ff[tail_addr];
      for (int i = 0; i < MAX_RAILS; i++) begin
         cand[i] = nonempty_ff[i] && (first_ff || (RAIL_W'(i) > drn_rail_ff));
      end
      nxt_found = |cand;
      nxt_rail  = '0;
      for (int i = MAX_RAILS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            nxt_rail = RAIL_W'(i);
         end
      end
      head_rd    = head_ff[nxt_rail];
      at_tail    = drn_idx_ff == tail_rd;
      end_now    = !first_ff && at_tail && !nxt_found;
      s1_move    = s1_v_ff && (!s2_v_ff || out_ready);
      s1_free    = !s1_v_ff || s1_move;
      issue      = draining && s1_free && (first_ff ? nxt_found : !end_now);
      jump       = first_ff || at_tail;
      issue_rail = jump ? nxt_rail : drn_rail_ff;
      issue_idx  = jump ? head_rd : next_q_ff;
      finish     = draining && ((first_ff && !nxt_found) || (end_now && s1_free));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_STORE: begin
            if (store_fire && q_entry.last) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (finish) begin
               state_in = BK_STORE;
            end
         end
         default: state_in = BK_STORE;
      endcase
   end

   always_comb begin
      q_pop       = 1'b0;
      case (state_ff)
         BK_STORE: q_pop = q_valid;
         BK_DRAIN: q_pop = 1'b0;
         default:  q_pop = 1'b0;
      endcase
      out_valid   = s2_v_ff;
      out_byte    = s2_byte_ff;
      out_last    = s2_last_ff;
      out_dropped = s2_drop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_STORE;
         nonempty_ff <= '0;
         fill_ff     <= '0;
         first_ff    <= 1'b0;
         drn_rail_ff <= '0;
         drn_idx_ff  <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (store_fire && q_entry.keep) begin
            nonempty_ff[q_rail] <= 1'b1;
            fill_ff             <= fill_ff + IDX_W'(1);
         end
         if (store_fire && q_entry.last) begin
            first_ff <= 1'b1;
         end
         if (issue) begin
            first_ff    <= 1'b0;
            drn_rail_ff <= issue_rail;
            drn_idx_ff  <= issue_idx;
         end
         if (finish) begin
            nonempty_ff <= '0;
            fill_ff     <= '0;
            first_ff    <= 1'b0;
         end
         if (issue) begin
            s1_v_ff <= 1'b1;
         end else if (s1_move) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_move) begin
            s2_v_ff <= 1'b1;
         end else if (out_ready) begin
            s2_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_fire && q_entry.keep) begin
         tail_ff[q_rail] <= fill_ff;
         if (!nonempty_ff[q_rail]) begin
            head_ff[q_rail] <= fill_ff;
         end
      end
      if (store_fire && q_entry.last) begin
         drop_ff <= q_entry.dropped;
      end
      if (s1_move) begin
         s2_byte_ff <= byte_q_ff;
         s2_last_ff <= end_now;
         s2_drop_ff <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store_fire && q_entry.keep) begin
         byte_mem[fill_ff] <= q_entry.data;
      end
      if (issue) begin
         byte_q_ff <= byte_mem[issue_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (store_fire && q_entry.keep && nonempty_ff[q_rail]) begin
         next_mem[tail_rd] <= fill_ff;
      end
      if (issue) begin
         next_q_ff <= next_mem[issue_idx];
      end
   end
endmodule
`default_nettype wire

>>> rtl/zigzag_rail_reorder_top.sv
// Zigzag rail reorder, top level: rail count register, front end, queue, engine.
// Depends on zrr_pkg, zrr_front, zrr_queue and zrr_back.
//
// Usage:
//   req channel carries one byte per transaction; tlast marks the final byte
//   of a block. rsp channel returns the block reordered by rail, tlast on the
//   final byte, tuser set on every byte if any input byte was dropped.
//   csr_we writes the rail count (1 to MAX_RAILS; 0 acts as 1); the user must
//   write it only while idle, which the block itself does not enforce. Each
//   byte is stored by the reorder engine; bytes beyond MAX_LEN per block are
//   dropped and flagged. After the final byte is stored, the engine enters its
//   drain state, reads the first byte into its first stage, moves it to the
//   output register, then gives one result per cycle while rsp_tready is high,
//   set by the single read port of the byte memory walking the per-rail lists.
//   The front end accepts up to four further bytes into its queue while a
//   block drains; req_tready falls when that queue is full.
//   A stalled receiver holds the output register and the drain pauses.
//   Reset is synchronous: it empties the queue and lists and sets the rail
//   count to one; no clearing pass is needed.
`default_nettype none
module zigzag_rail_reorder_top import zrr_pkg::*; #(
   parameter int MAX_LEN   = 64,
   parameter int MAX_RAILS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [RC_W-1:0]   csr_wdata,     // rail_count
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,     // in_byte
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,     // out_byte
   output logic              rsp_tlast,
   output logic [0:0]        rsp_tuser      // dropped
);
   localparam int RAIL_W = $clog2(MAX_RAILS);
   localparam int QW     = $bits(entry_type) + RAIL_W;

   logic [RC_W-1:0]   rail_count_ff;
   logic              take;
   entry_type         f_entry;
   logic [RAIL_W-1:0] f_rail;
   logic              q_full;
   logic              q_pop;
   logic              q_valid;
   logic [QW-1:0]     q_out;
   entry_type         q_entry;
   logic [RAIL_W-1:0] q_rail;
   logic              drop_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rail_count_ff <= RC_W'(1);
      end else if (csr_we) begin
         rail_count_ff <= csr_wdata;
      end
   end

   always_comb begin
      req_tready   = !q_full;
      take         = req_tvalid && !q_full;
      q_entry      = q_out[QW-1:RAIL_W];
      q_rail       = q_out[RAIL_W-1:0];
      rsp_tuser[0] = drop_bit;
   end

   zrr_front #(
      .MAX_LEN   (MAX_LEN),
      .MAX_RAILS (MAX_RAILS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .rail_count (rail_count_ff),
      .take       (take),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .entry      (f_entry),
      .entry_rail (f_rail)
   );

   zrr_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data ({f_entry, f_rail}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .not_empty (q_valid)
   );

   zrr_back #(
      .MAX_LEN   (MAX_LEN),
      .MAX_RAILS (MAX_RAILS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_rail      (q_rail),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast),
      .out_dropped (drop_bit)
   );
endmodule
`default_nettype wire

>>> rtl/zrr_checker.sv
// Port-level checks for the zigzag rail reorder block, bound to the top level.
// Depends on zigzag_rail_reorder_top_assert.svh.
`default_nettype none
`include "zigzag_rail_reorder_top_assert.svh"
module zrr_checker #(
   parameter  int MAX_LEN = 64,
   localparam int CNT_W   = $clog2(MAX_LEN + 1)
) (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser
);
   logic [7:0]       pend_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             drop_ff;
   logic             in_end;
   logic             out_end;
   logic             out_fire;
   logic             rsp_stall;
   logic [10:0]      rsp_word;
   logic             mid_block;

   always_comb begin
      in_end    = req_tvalid && req_tready && req_tlast;
      out_fire  = rsp_tvalid && rsp_tready;
      out_end   = out_fire && rsp_tlast;
      rsp_stall = rsp_tvalid && !rsp_tready;
      rsp_word  = {rsp_tvalid, rsp_tdata, rsp_tlast, rsp_tuser};
      mid_block = rsp_tvalid && (cnt_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         pend_ff <= pend_ff + 8'(in_end) - 8'(out_end);
         if (out_end) begin
            cnt_ff <= '0;
         end else if (out_fire) begin
            cnt_ff  <= cnt_ff + CNT_W'(1);
            drop_ff <= rsp_tuser[0];
         end
      end
   end

   `ZRR_ASSERT_NEXT(rsp_hold_chk, rsp_stall, $stable(rsp_word), "rsp changed while stalled")
   `ZRR_ASSERT_NOW(rsp_cause_chk, rsp_tvalid, pend_ff != 8'd0, "result without input block")
   `ZRR_ASSERT_NOW(rsp_drop_chk, mid_block, rsp_tuser[0] == drop_ff, "drop flag changed")
   `ZRR_ASSERT_NOW(rsp_len_chk, rsp_tvalid, cnt_ff < CNT_W'(MAX_LEN), "block too long")
endmodule

bind zigzag_rail_reorder_top zrr_checker #(
   .MAX_LEN (MAX_LEN)
) u_zrr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
